// ===== rtl/mnbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and width helpers for the masked nearest bitmap scaler.
// Used by every module in rtl/; depends on nothing.
package mnbs_pkg;

    localparam int DEF_MAX_DIMENSION = 2048;
    localparam int DEF_MAX_SCALE     = 4;
    localparam int QUEUE_DEPTH       = 4;

    localparam int PIXEL_W  = 8;
    localparam int COORD_W  = 11;
    localparam int CFG_W    = 12;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [PIXEL_W-1:0] KEY_COLOUR = 8'd255;

    localparam logic [CFG_W-1:0] RST_SRC_W = 12'd320;
    localparam logic [CFG_W-1:0] RST_SRC_H = 12'd200;
    localparam logic [CFG_W-1:0] RST_TGT_W = 12'd320;
    localparam logic [CFG_W-1:0] RST_TGT_H = 12'd200;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SRC_W = 2'd0,
        REG_SRC_H = 2'd1,
        REG_TGT_W = 2'd2,
        REG_TGT_H = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_RUN = 2'b01,
        S_DIV = 2'b10
    } t_front_state;

    typedef struct packed {
        logic [CFG_W-1:0] src_w;
        logic [CFG_W-1:0] src_h;
        logic [CFG_W-1:0] tgt_w;
        logic [CFG_W-1:0] tgt_h;
    } t_size_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic int dim_width(input int max_dim);
        return $clog2(max_dim + 1);
    endfunction

    function automatic int rpt_width(input int max_scale);
        return $clog2(max_scale + 1);
    endfunction

    // job layout: {pixel, x, y, col_repeats, row_repeats}
    function automatic int job_width(input int max_dim, input int max_scale);
        return PIXEL_W + 2 * dim_width(max_dim) + 2 * rpt_width(max_scale);
    endfunction

endpackage

// ===== rtl/mnbs_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts source pixels, runs the ratio divider at frame start and the
// Bresenham error steps, and queues one job per repeating pixel. Uses mnbs_pkg.
module mnbs_front #(
    parameter int MAX_DIMENSION = 2048,
    parameter int MAX_SCALE     = 4
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  mnbs_pkg::t_size_cfg                                    i_cfg,
    input  logic                                                   i_valid,
    input  logic [mnbs_pkg::PIXEL_W-1:0]                           i_pixel_in,
    output logic                                                   o_stall,
    input  mnbs_pkg::t_queue_status                                i_queue,
    output logic                                                   o_push,
    output logic [mnbs_pkg::job_width(MAX_DIMENSION, MAX_SCALE)-1:0] o_job
);
    import mnbs_pkg::*;

    localparam int DIM_W = dim_width(MAX_DIMENSION);
    localparam int RPT_W = rpt_width(MAX_SCALE);
    localparam int LIM_W = DIM_W + RPT_W;
    localparam int CMP_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;

    function automatic logic [DIM_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (w == '0) begin
            clamp_size = DIM_W'(1);
        end else if (w > CMP_W'(MAX_DIMENSION)) begin
            clamp_size = DIM_W'(MAX_DIMENSION);
        end else begin
            clamp_size = DIM_W'(w);
        end
    endfunction

    t_front_state       r_state;
    logic [PIXEL_W-1:0] r_pix;
    logic [DIM_W-1:0]   r_sw, r_sh;
    logic [DIM_W-1:0]   r_wr, r_hr;
    logic [RPT_W-1:0]   r_wq, r_hq;
    logic [DIM_W-1:0]   r_col_err, r_row_err;
    logic [DIM_W-1:0]   r_src_col, r_src_row;
    logic [DIM_W-1:0]   r_tgt_col, r_tgt_row;
    logic [RPT_W-1:0]   r_row_rep;

    logic [DIM_W-1:0] sw_c, sh_c, tw_c, th_c, tw_fit, th_fit;
    logic [LIM_W-1:0] w_lim, h_lim;
    logic             accept, frame_start, proc;
    logic             w_sub, h_sub, div_done;
    logic [PIXEL_W-1:0] pix;
    logic             col0, row_end, frame_end;
    logic [DIM_W:0]   row_sum, col_sum, src_col_inc, src_row_inc;
    logic             row_wrap, col_wrap;
    logic [DIM_W-1:0] n_row_err, n_col_err, col_base, tcol_base;
    logic [RPT_W-1:0] rrep, crep;

    // frame latch: clamp sizes and limit each target to MAX_SCALE times its source
    always_comb begin
        sw_c  = clamp_size(i_cfg.src_w);
        sh_c  = clamp_size(i_cfg.src_h);
        tw_c  = clamp_size(i_cfg.tgt_w);
        th_c  = clamp_size(i_cfg.tgt_h);
        w_lim = LIM_W'(sw_c) * LIM_W'(MAX_SCALE);
        h_lim = LIM_W'(sh_c) * LIM_W'(MAX_SCALE);
        tw_fit = (LIM_W'(tw_c) > w_lim) ? DIM_W'(w_lim) : tw_c;
        th_fit = (LIM_W'(th_c) > h_lim) ? DIM_W'(h_lim) : th_c;
    end

    assign o_stall     = !((r_state == S_RUN) && !i_queue.full);
    assign accept      = i_valid && !o_stall;
    assign frame_start = (r_src_col == '0) && (r_src_row == '0);

    // ratio divider: quotient never exceeds MAX_SCALE, so repeated subtraction
    assign w_sub    = (r_wr >= r_sw);
    assign h_sub    = (r_hr >= r_sh);
    assign div_done = !w_sub && !h_sub;

    assign proc = ((r_state == S_RUN) && accept && !frame_start) ||
                  ((r_state == S_DIV) && div_done && !i_queue.full);

    always_comb begin
        pix  = (r_state == S_DIV) ? r_pix : i_pixel_in;
        col0 = (r_src_col == '0);

        row_sum   = {1'b0, r_row_err} + {1'b0, r_hr};
        row_wrap  = (row_sum >= {1'b0, r_sh});
        n_row_err = row_wrap ? DIM_W'(row_sum - {1'b0, r_sh}) : DIM_W'(row_sum);
        if (col0) begin
            rrep = row_wrap ? RPT_W'(r_hq + RPT_W'(1)) : r_hq;
        end else begin
            rrep = r_row_rep;
        end

        col_base  = col0 ? '0 : r_col_err;
        col_sum   = {1'b0, col_base} + {1'b0, r_wr};
        col_wrap  = (col_sum >= {1'b0, r_sw});
        n_col_err = col_wrap ? DIM_W'(col_sum - {1'b0, r_sw}) : DIM_W'(col_sum);
        crep      = col_wrap ? RPT_W'(r_wq + RPT_W'(1)) : r_wq;
        tcol_base = col0 ? '0 : r_tgt_col;

        src_col_inc = {1'b0, r_src_col} + (DIM_W + 1)'(1);
        src_row_inc = {1'b0, r_src_row} + (DIM_W + 1)'(1);
        row_end     = (src_col_inc >= {1'b0, r_sw});
        frame_end   = row_end && (src_row_inc >= {1'b0, r_sh});
    end

    // drop pixels that repeat zero times in either direction
    assign o_push = proc && (crep != '0) && (rrep != '0);
    assign o_job  = {pix, tcol_base, r_tgt_row, crep, rrep};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_src_col <= '0;
            r_src_row <= '0;
        end else begin
            unique case (r_state)
                S_RUN: begin
                    if (accept && frame_start) begin
                        r_pix     <= i_pixel_in;
                        r_sw      <= sw_c;
                        r_sh      <= sh_c;
                        r_wr      <= tw_fit;
                        r_hr      <= th_fit;
                        r_wq      <= '0;
                        r_hq      <= '0;
                        r_row_err <= '0;
                        r_tgt_row <= '0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_sub) begin
                        r_wr <= r_wr - r_sw;
                        r_wq <= r_wq + RPT_W'(1);
                    end
                    if (h_sub) begin
                        r_hr <= r_hr - r_sh;
                        r_hq <= r_hq + RPT_W'(1);
                    end
                    if (div_done && !i_queue.full) begin
                        r_state <= S_RUN;
                    end
                end
                default: r_state <= S_RUN;
            endcase

            if (proc) begin
                r_row_rep <= rrep;
                r_col_err <= n_col_err;
                r_tgt_col <= DIM_W'(tcol_base + DIM_W'(crep));
                if (col0 && !frame_end) begin
                    r_row_err <= n_row_err;
                end
                if (row_end) begin
                    r_src_col <= '0;
                    if (frame_end) begin
                        r_src_row <= '0;
                        r_tgt_row <= '0;
                        r_row_err <= '0;
                    end else begin
                        r_src_row <= DIM_W'(src_row_inc);
                        r_tgt_row <= DIM_W'(r_tgt_row + DIM_W'(rrep));
                    end
                end else begin
                    r_src_col <= DIM_W'(src_col_inc);
                end
            end
        end
    end

endmodule

// ===== rtl/mnbs_queue.sv =====
`timescale 1ns / 1ps
// Small job FIFO between the front end and the write generator.
// Uses mnbs_pkg for the status struct.
module mnbs_queue #(
    parameter int DEPTH  = 4,
    parameter int DATA_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [DATA_W-1:0]       i_data,
    input  logic                    i_pop,
    output logic [DATA_W-1:0]       o_data,
    output mnbs_pkg::t_queue_status o_status
);
    import mnbs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + PTR_W'(1));
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + PTR_W'(1));
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/mnbs_back.sv =====
`timescale 1ns / 1ps
// Write generator: walks each queued job row by row, column by column, one
// destination write per cycle into the output register unless stalled. Uses mnbs_pkg.
module mnbs_back #(
    parameter int MAX_DIMENSION = 2048,
    parameter int MAX_SCALE     = 4
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic [mnbs_pkg::job_width(MAX_DIMENSION, MAX_SCALE)-1:0] i_job,
    input  mnbs_pkg::t_queue_status                                i_queue,
    output logic                                                   o_pop,
    output logic                                                   o_valid,
    input  logic                                                   i_stall,
    output logic [mnbs_pkg::COORD_W-1:0]                           o_out_x,
    output logic [mnbs_pkg::COORD_W-1:0]                           o_out_y,
    output logic [mnbs_pkg::PIXEL_W-1:0]                           o_out_pixel,
    output logic                                                   o_write_enable,
    output logic                                                   o_last_write
);
    import mnbs_pkg::*;

    localparam int DIM_W = dim_width(MAX_DIMENSION);
    localparam int RPT_W = rpt_width(MAX_SCALE);
    localparam int JOB_W = job_width(MAX_DIMENSION, MAX_SCALE);
    localparam int NCOL_LO = RPT_W;
    localparam int Y_LO    = 2 * RPT_W;
    localparam int X_LO    = Y_LO + DIM_W;
    localparam int PIX_LO  = X_LO + DIM_W;

    logic [RPT_W-1:0]   r_cx, r_ry;
    logic               r_valid;
    logic [COORD_W-1:0] r_x, r_y;
    logic [PIXEL_W-1:0] r_pix;
    logic               r_we, r_last;

    logic [RPT_W-1:0]   nrow, ncol;
    logic [DIM_W-1:0]   job_x, job_y;
    logic [PIXEL_W-1:0] job_pix;
    logic               load, emit, last_col, last_row;

    assign nrow    = i_job[RPT_W-1:0];
    assign ncol    = i_job[Y_LO-1:NCOL_LO];
    assign job_y   = i_job[X_LO-1:Y_LO];
    assign job_x   = i_job[PIX_LO-1:X_LO];
    assign job_pix = i_job[JOB_W-1:PIX_LO];

    // output register frees when empty or when its item is taken
    assign load     = !r_valid || !i_stall;
    assign emit     = load && !i_queue.empty;
    assign last_col = (r_cx == RPT_W'(ncol - RPT_W'(1)));
    assign last_row = (r_ry == RPT_W'(nrow - RPT_W'(1)));
    assign o_pop    = emit && last_col && last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cx    <= '0;
            r_ry    <= '0;
        end else begin
            r_valid <= emit || (r_valid && i_stall);
            if (emit) begin
                if (last_col) begin
                    r_cx <= '0;
                    r_ry <= last_row ? '0 : RPT_W'(r_ry + RPT_W'(1));
                end else begin
                    r_cx <= RPT_W'(r_cx + RPT_W'(1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_x    <= COORD_W'(DIM_W'(job_x + DIM_W'(r_cx)));
            r_y    <= COORD_W'(DIM_W'(job_y + DIM_W'(r_ry)));
            r_pix  <= job_pix;
            r_we   <= (job_pix != KEY_COLOUR);
            r_last <= last_col && last_row;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_x        = r_x;
    assign o_out_y        = r_y;
    assign o_out_pixel    = r_pix;
    assign o_write_enable = r_we;
    assign o_last_write   = r_last;

endmodule

// ===== rtl/masked_nearest_bitmap_scaler.sv =====
`timescale 1ns / 1ps
// Top level of the masked nearest bitmap scaler: APB size registers and the
// front end, job queue and write generator. Uses mnbs_pkg.

// Source pixels enter in raster order, one per cycle while the job queue has
// room and the ratio divider is idle; each becomes row_repeats x col_repeats
// destination writes (0 to MAX_SCALE*MAX_SCALE, 16 at the defaults) that
// leave one per cycle while i_stall is low, rows outer and columns inner, so
// the write generator sets the rate. The first pixel of each frame latches
// the size registers and passes through the ratio divider before its job is
// queued. Sizes are clamped to 1..MAX_DIMENSION and each target to MAX_SCALE
// times its source; size writes take effect at the next frame start. Writes
// of key colour 255 come out with o_write_enable low, and o_last_write marks
// the final write of each pixel (a pixel that repeats zero times makes no
// write at all).
module masked_nearest_bitmap_scaler #(
    parameter int MAX_DIMENSION = mnbs_pkg::DEF_MAX_DIMENSION,
    parameter int MAX_SCALE     = mnbs_pkg::DEF_MAX_SCALE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mnbs_pkg::PADDR_W-1:0]  paddr,
    input  logic [mnbs_pkg::APB_W-1:0]    pwdata,
    output logic [mnbs_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_valid,
    input  logic [mnbs_pkg::PIXEL_W-1:0]  i_pixel_in,
    output logic                          o_stall,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mnbs_pkg::COORD_W-1:0]  o_out_x,
    output logic [mnbs_pkg::COORD_W-1:0]  o_out_y,
    output logic [mnbs_pkg::PIXEL_W-1:0]  o_out_pixel,
    output logic                          o_write_enable,
    output logic                          o_last_write
);
    import mnbs_pkg::*;

    localparam int JOB_W = job_width(MAX_DIMENSION, MAX_SCALE);

    t_size_cfg     r_cfg;
    t_reg_idx      reg_idx;
    logic          cfg_wr;
    t_queue_status q_status;
    logic          push, pop;
    logic [JOB_W-1:0] push_job, head_job;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:PADDR_W-REG_IDX_W]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_w <= RST_SRC_W;
            r_cfg.src_h <= RST_SRC_H;
            r_cfg.tgt_w <= RST_TGT_W;
            r_cfg.tgt_h <= RST_TGT_H;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SRC_W: r_cfg.src_w <= pwdata[CFG_W-1:0];
                REG_SRC_H: r_cfg.src_h <= pwdata[CFG_W-1:0];
                REG_TGT_W: r_cfg.tgt_w <= pwdata[CFG_W-1:0];
                REG_TGT_H: r_cfg.tgt_h <= pwdata[CFG_W-1:0];
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SRC_W: prdata = APB_W'(r_cfg.src_w);
            REG_SRC_H: prdata = APB_W'(r_cfg.src_h);
            REG_TGT_W: prdata = APB_W'(r_cfg.tgt_w);
            REG_TGT_H: prdata = APB_W'(r_cfg.tgt_h);
            default:   prdata = '0;
        endcase
    end

    mnbs_front #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .MAX_SCALE     (MAX_SCALE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .i_pixel_in (i_pixel_in),
        .o_stall    (o_stall),
        .i_queue    (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    mnbs_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_job),
        .i_pop    (pop),
        .o_data   (head_job),
        .o_status (q_status)
    );

    mnbs_back #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .MAX_SCALE     (MAX_SCALE)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (head_job),
        .i_queue        (q_status),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_pixel    (o_out_pixel),
        .o_write_enable (o_write_enable),
        .o_last_write   (o_last_write)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for masked_nearest_bitmap_scaler: APB size setup,
// pixel stimulus, a scaling predictor and a write checker. Uses mnbs_pkg.
module testbench;
    import mnbs_pkg::*;

    localparam int MAX_DIMENSION   = DEF_MAX_DIMENSION;
    localparam int MAX_SCALE       = DEF_MAX_SCALE;
    localparam int GAP_MAX         = 14;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_STOP     = 385;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIXEL_W-1:0] pixel;
        logic               we;
        logic               last_wr;
    } t_scaler_write;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_W-1:0]   pwdata;
    logic [APB_W-1:0]   prdata;
    logic               pready;
    logic               i_valid;
    logic [PIXEL_W-1:0] i_pixel_in;
    logic               o_stall;
    logic               o_valid;
    logic               i_stall;
    logic [COORD_W-1:0] o_out_x;
    logic [COORD_W-1:0] o_out_y;
    logic [PIXEL_W-1:0] o_out_pixel;
    logic               o_write_enable;
    logic               o_last_write;

    masked_nearest_bitmap_scaler i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .i_pixel_in     (i_pixel_in),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_pixel    (o_out_pixel),
        .o_write_enable (o_write_enable),
        .o_last_write   (o_last_write)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copies and scaling state of the predictor
    logic [CFG_W-1:0] reg_src_w = RST_SRC_W;
    logic [CFG_W-1:0] reg_src_h = RST_SRC_H;
    logic [CFG_W-1:0] reg_tgt_w = RST_TGT_W;
    logic [CFG_W-1:0] reg_tgt_h = RST_TGT_H;
    logic [11:0] frame_w = 12'd1;
    logic [11:0] frame_h = 12'd1;
    logic [2:0]  width_quot = '0;
    logic [10:0] width_rem = '0;
    logic [2:0]  height_quot = '0;
    logic [10:0] height_rem = '0;
    logic [11:0] col_err = '0;
    logic [11:0] row_err = '0;
    logic [11:0] src_col = '0;
    logic [11:0] src_row = '0;
    logic [11:0] tgt_col = '0;
    logic [11:0] tgt_row = '0;
    logic [2:0]  row_rep = '0;

    t_scaler_write pending_writes[$];

    int  fail_count = 0;
    int  pixels_sent = 0;
    int  writes_checked = 0;
    int  masked_writes = 0;
    int  size_settings = 0;
    int  quiet_cycles = 0;
    int  hold_off_request = 0;
    bit  sender_gaps_on = 1'b1;
    bit  receiver_gaps_on = 1'b1;

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > MAX_DIMENSION) return MAX_DIMENSION;
        return v;
    endfunction

    function automatic int unsigned next_frame_pixels();
        return clamp_dim(reg_src_w) * clamp_dim(reg_src_h);
    endfunction

    function automatic void latch_frame_sizes();
        int unsigned sw, sh, tw, th;
        sw = clamp_dim(reg_src_w);
        sh = clamp_dim(reg_src_h);
        tw = clamp_dim(reg_tgt_w);
        th = clamp_dim(reg_tgt_h);
        if (tw > sw * MAX_SCALE) tw = sw * MAX_SCALE;
        if (th > sh * MAX_SCALE) th = sh * MAX_SCALE;
        frame_w     = 12'(sw);
        frame_h     = 12'(sh);
        width_quot  = 3'(tw / sw);
        width_rem   = 11'(tw % sw);
        height_quot = 3'(th / sh);
        height_rem  = 11'(th % sh);
    endfunction

    // Expand one source pixel into the destination writes it covers
    function automatic void predict_writes(logic [PIXEL_W-1:0] pix);
        logic [2:0]    col_rep;
        t_scaler_write w;
        int            total;
        if (src_col == 0 && src_row == 0) begin
            latch_frame_sizes();
            tgt_row = '0;
            row_err = '0;
        end
        if (src_col == 0) begin
            row_err = row_err + height_rem;
            if (row_err >= frame_h) begin
                row_err = row_err - frame_h;
                row_rep = height_quot + 3'd1;
            end else begin
                row_rep = height_quot;
            end
            col_err = '0;
            tgt_col = '0;
        end
        col_err = col_err + width_rem;
        if (col_err >= frame_w) begin
            col_err = col_err - frame_w;
            col_rep = width_quot + 3'd1;
        end else begin
            col_rep = width_quot;
        end
        total = row_rep * col_rep;
        for (int ry = 0; ry < row_rep; ry++) begin
            for (int cx = 0; cx < col_rep; cx++) begin
                w.x       = COORD_W'(tgt_col + cx);
                w.y       = COORD_W'(tgt_row + ry);
                w.pixel   = pix;
                w.we      = (pix != KEY_COLOUR);
                w.last_wr = (ry * col_rep + cx == total - 1);
                pending_writes.push_back(w);
            end
        end
        tgt_col = tgt_col + col_rep;
        src_col = src_col + 12'd1;
        if (src_col >= frame_w) begin
            src_col = '0;
            tgt_row = tgt_row + row_rep;
            src_row = src_row + 12'd1;
            if (src_row >= frame_h) begin
                src_row = '0;
                tgt_row = '0;
                row_err = '0;
            end
        end
    endfunction

    function automatic logic [PIXEL_W-1:0] draw_pixel();
        case ($urandom_range(0, 19))
            0, 1, 2: return KEY_COLOUR;
            3, 4:    return '0;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_source(int unsigned common_max);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'($urandom_range(common_max + 1, 3 * common_max + 2));
            default: return CFG_W'($urandom_range(1, common_max));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_target(logic [CFG_W-1:0] src_reg);
        int unsigned s;
        s = clamp_dim(src_reg);
        case ($urandom_range(0, 5))
            0:       return CFG_W'($urandom_range(0, s));
            1, 2:    return CFG_W'($urandom_range(s, MAX_SCALE * s));
            3:       return {CFG_W{1'b1}};
            4:       return CFG_W'($urandom_range(MAX_SCALE * s, MAX_SCALE * s + 8));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // Wait for every expected write, then let the scaler settle
    task automatic wait_idle();
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size_reg(t_reg_idx idx, logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SRC_W: reg_src_w = val;
            REG_SRC_H: reg_src_h = val;
            REG_TGT_W: reg_tgt_w = val;
            REG_TGT_H: reg_tgt_h = val;
        endcase
    endtask

    task automatic set_sizes(logic [CFG_W-1:0] sw, logic [CFG_W-1:0] sh,
                             logic [CFG_W-1:0] tw, logic [CFG_W-1:0] th);
        wait_idle();
        write_size_reg(REG_SRC_W, sw);
        write_size_reg(REG_SRC_H, sh);
        write_size_reg(REG_TGT_W, tw);
        write_size_reg(REG_TGT_H, th);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_settings++;
    endtask

    // Offer one pixel; hold valid high when the next item follows at once
    task automatic send_pixel(logic [PIXEL_W-1:0] pix, bit more);
        int gap;
        i_valid    <= 1'b1;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (o_stall);
        predict_writes(pix);
        pixels_sent++;
        gap = sender_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
        if (!more || gap != 0) i_valid <= 1'b0;
        if (more && gap != 0) repeat (gap) @(posedge i_clk);
    endtask

    task automatic send_frames(int frames);
        int total;
        total = frames * next_frame_pixels();
        for (int i = 0; i < total; i++) send_pixel(draw_pixel(), i != total - 1);
    endtask

    task automatic test_directed_cases();
        logic [PIXEL_W-1:0] shrink_px [8] = '{8'h10, 8'hFF, 8'h7F, 8'h80,
                                               8'h01, 8'hFE, 8'hFF, 8'h00};
        // full 4x upscale: sixteen writes per pixel, key colour included
        set_sizes(12'd2, 12'd2, 12'd8, 12'd8);
        send_pixel(8'h00, 1);
        send_pixel(KEY_COLOUR, 1);
        send_pixel(8'hAA, 1);
        send_pixel(8'h55, 0);
        // zero sizes clamp up to one, oversized targets clamp to the scale limit
        set_sizes(12'd0, 12'd0, 12'hFFF, 12'hFFF);
        send_pixel(KEY_COLOUR, 1);
        send_pixel(8'h01, 0);
        // shrink: first row and first pixel repeat zero times
        set_sizes(12'd4, 12'd2, 12'd3, 12'd1);
        for (int i = 0; i < 8; i++) send_pixel(shrink_px[i], i != 7);
        // sizes written mid-frame apply only from the next frame start
        set_sizes(12'd2, 12'd2, 12'd4, 12'd4);
        send_pixel(8'h01, 1);
        send_pixel(8'hFE, 0);
        set_sizes(12'd3, 12'd1, 12'd3, 12'd3);
        send_pixel(8'h80, 1);
        send_pixel(KEY_COLOUR, 0);
        send_frames(1);
    endtask

    task automatic test_backpressure();
        set_sizes(12'd4, 12'd4, 12'd16, 12'd16);
        sender_gaps_on   = 1'b0;
        receiver_gaps_on = 1'b1;
        hold_off_request = HOLD_OFF_CYCLES;
        send_frames(1);
        sender_gaps_on = 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < 8; i++) send_pixel(draw_pixel(), i != 7);
        wait_idle();
        for (int i = 0; i < 8; i++) send_pixel(draw_pixel(), i != 7);
    endtask

    task automatic test_random_scaling();
        logic [CFG_W-1:0] sw, sh;
        int frames;
        while (pixels_sent < RANDOM_STOP) begin
            sw = pick_source(6);
            sh = pick_source(4);
            set_sizes(sw, sh, pick_target(sw), pick_target(sh));
            sender_gaps_on   = ($urandom_range(0, 3) != 0);
            receiver_gaps_on = ($urandom_range(0, 3) != 0);
            frames = (next_frame_pixels() <= 40) ? $urandom_range(1, 2) : 1;
            send_frames(frames);
        end
    endtask

    // Widest frame: start of a 2048-pixel row, left unfinished at the end
    task automatic test_wide_frame();
        set_sizes(12'd2048, 12'hFFF, 12'hFFF, 12'd2048);
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
        for (int i = 0; i < 24; i++) send_pixel(draw_pixel(), i != 23);
    endtask

    initial begin : receiver
        int stall_len;
        i_stall = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_request > 0) begin
                stall_len = hold_off_request;
                hold_off_request = 0;
            end else begin
                stall_len = receiver_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin : check_writes
        t_scaler_write exp_w, got_w;
        if (i_rst_n && o_valid && !i_stall) begin
            got_w = {o_out_x, o_out_y, o_out_pixel, o_write_enable, o_last_write};
            if (pending_writes.size() == 0) begin
                if (fail_count < REPORT_LIMIT)
                    $display("MISMATCH unexpected write x=%0d y=%0d px=%02h we=%b last=%b",
                             got_w.x, got_w.y, got_w.pixel, got_w.we, got_w.last_wr);
                fail_count++;
            end else begin
                exp_w = pending_writes.pop_front();
                writes_checked++;
                if (!exp_w.we) masked_writes++;
                if (got_w.x !== exp_w.x || got_w.y !== exp_w.y ||
                        got_w.pixel !== exp_w.pixel || got_w.we !== exp_w.we ||
                        got_w.last_wr !== exp_w.last_wr) begin
                    if (fail_count < REPORT_LIMIT)
                        $display({"MISMATCH write %0d: expected x=%0d y=%0d px=%02h we=%b ",
                                  "last=%b, got x=%0d y=%0d px=%02h we=%b last=%b"},
                                 writes_checked, exp_w.x, exp_w.y, exp_w.pixel, exp_w.we,
                                 exp_w.last_wr, got_w.x, got_w.y, got_w.pixel, got_w.we,
                                 got_w.last_wr);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles in which neither channel moves an item
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_pixel_in = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_backpressure();
        test_random_scaling();
        test_wide_frame();
        wait_idle();

        fail_count += pending_writes.size();
        $display("Scaler run: %0d source pixels over %0d size settings, %0d writes checked",
                 pixels_sent, size_settings, writes_checked);
        $display("  (%0d of them masked as key colour, %0d failures)",
                 masked_writes, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
